### rtl/lols_pkg.sv
// Shared types and constants for the linear octree locate and split block.
// Used by the top level and by the existence store; depends on nothing.
package lols_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_LOCATE = 2'd0;
  localparam op_t OP_SPLIT  = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_MISSING = 2'd1;
  localparam status_t ST_SPLIT   = 2'd2;
  localparam status_t ST_DEPTH0  = 2'd3;

  localparam logic REG_ROOT_SIZE  = 1'b0;
  localparam logic REG_ROOT_DEPTH = 1'b1;

  localparam int CFG_W = 17;
  localparam logic [CFG_W-1:0] RESET_ROOT_SIZE = 17'd256;
  localparam logic [2:0] RESET_ROOT_DEPTH = 3'd4;

  // One store row holds the eight siblings that share a parent.
  localparam int ROW_BITS = 8;
  localparam logic [ROW_BITS-1:0] ROOT_ROW = 8'b0000_0010;

endpackage

### rtl/lols_mem.sv
// Existence store: one row of eight sibling bits per parent code.
// Synchronous single-port write, registered read; uses lols_pkg.
module lols_mem #(
  parameter int ROW_W = 10
) (
  input  logic                          clk,
  input  logic                          re,
  input  logic [ROW_W-1:0]              raddr,
  input  logic                          we,
  input  logic [ROW_W-1:0]              waddr,
  input  logic [lols_pkg::ROW_BITS-1:0] wdata,
  output logic [lols_pkg::ROW_BITS-1:0] rdata
);

  logic [lols_pkg::ROW_BITS-1:0] mem [2**ROW_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/linear_octree_locate_split.sv
// Locate: one store read per level walked.
// Split: ends at the first read if refused there, else two reads, then a write unless already split.
// Remove: a read, then a write for a valid code; an unknown operation goes straight to the result.
// The result is registered in S_OUT once the output register is free.
// Synchronous active-low reset; afterwards the store is cleared one row a
// cycle, 2**(3*MAX_DEPTH-2) rows (1024 by default), with no input taken.
module linear_octree_locate_split #(
  parameter int MAX_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [lols_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // point_x, point_y, point_z, node_code, zero fill
  input  logic [63:0]                in_tdata,
  // operation
  input  logic [1:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // status, leaf_code, center_x, center_y, center_z, half_size, node_depth, zero fill
  output logic [87:0]                out_tdata
);

  localparam int CODE_W = 3 * MAX_DEPTH + 1;
  localparam int ROW_W  = CODE_W - 3;
  localparam int EXT_W  = (CODE_W > 13) ? CODE_W : 13;
  localparam int LVL_W  = $clog2(MAX_DEPTH + 1);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LROOT = 3'd2;
  localparam logic [2:0] S_LWALK = 3'd3;
  localparam logic [2:0] S_SPCHK = 3'd4;
  localparam logic [2:0] S_SPCH0 = 3'd5;
  localparam logic [2:0] S_RMRD  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                 state_r, state_nxt;
  logic [ROW_W-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [16:0]                root_size_r;
  logic [2:0]                 root_depth_r;
  lols_pkg::op_t              op_r, op_nxt;
  lols_pkg::status_t          status_r, status_nxt;
  logic signed [15:0]         px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [12:0]                code_r, code_nxt;
  logic [CODE_W-1:0]          cur_r, cur_nxt;
  logic signed [17:0]         cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [15:0]                half_r, half_nxt;
  logic [LVL_W-1:0]           lvl_r, lvl_nxt;
  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [87:0]                out_tdata_r, out_tdata_nxt;

  logic                          mem_re, mem_we;
  logic [ROW_W-1:0]              mem_raddr, mem_waddr;
  logic [lols_pkg::ROW_BITS-1:0] mem_wdata, mem_rdata;

  logic [EXT_W-1:0]   in_code_ext, code_ext, cur_ext;
  logic               spl_valid;
  logic [LVL_W-1:0]   spl_lvl;
  logic signed [17:0] px_e, py_e, pz_e, ch_e;
  logic [15:0]        half_child;
  logic [2:0]         oct;
  logic [CODE_W-1:0]  child;
  logic [2:0]         lvl_e, depth_val;
  logic [12:0]        leaf_val;
  logic               geo;

  lols_mem #(.ROW_W(ROW_W)) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign in_code_ext = EXT_W'(in_tdata[60:48]);
  assign code_ext    = EXT_W'(code_r);
  assign cur_ext     = EXT_W'(cur_r);

  // A code is valid when its top set bit sits at a multiple of three.
  always_comb begin
    spl_valid = 1'b0;
    spl_lvl   = '0;
    for (int l = 0; l <= MAX_DEPTH; l++) begin
      if ((code_ext >> (3 * l)) == EXT_W'(1)) begin
        spl_valid = 1'b1;
        spl_lvl   = LVL_W'(l);
      end
    end
  end

  assign px_e       = 18'(px_r);
  assign py_e       = 18'(py_r);
  assign pz_e       = 18'(pz_r);
  assign half_child = half_r >> 1;
  assign ch_e       = signed'({2'b00, half_child});
  assign oct        = {pz_e > cz_r, py_e > cy_r, px_e > cx_r};
  assign child      = {cur_r[CODE_W-4:0], oct};

  assign lvl_e     = 3'(lvl_r);
  assign depth_val = (lvl_e > root_depth_r) ? 3'd0 : root_depth_r - lvl_e;
  assign geo       = (op_r == lols_pkg::OP_LOCATE);

  always_comb begin
    case (op_r)
      lols_pkg::OP_LOCATE: leaf_val = cur_ext[12:0];
      lols_pkg::OP_SPLIT,
      lols_pkg::OP_REMOVE: leaf_val = code_r;
      default:             leaf_val = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    pz_nxt         = pz_r;
    code_nxt       = code_r;
    cur_nxt        = cur_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cz_nxt         = cz_r;
    half_nxt       = half_r;
    lvl_nxt        = lvl_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    case (state_r)
      S_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = (clr_cnt_r == '0) ? lols_pkg::ROOT_ROW : '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {ROW_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          px_nxt     = in_tdata[15:0];
          py_nxt     = in_tdata[31:16];
          pz_nxt     = in_tdata[47:32];
          code_nxt   = in_tdata[60:48];
          status_nxt = lols_pkg::ST_OK;
          cur_nxt    = CODE_W'(1);
          cx_nxt     = '0;
          cy_nxt     = '0;
          cz_nxt     = '0;
          half_nxt   = root_size_r[16:1];
          lvl_nxt    = '0;
          case (in_tuser)
            lols_pkg::OP_LOCATE: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_nxt = S_LROOT;
            end
            lols_pkg::OP_SPLIT: begin
              mem_re    = 1'b1;
              mem_raddr = in_code_ext[CODE_W-1:3];
              state_nxt = S_SPCHK;
            end
            lols_pkg::OP_REMOVE: begin
              mem_re    = 1'b1;
              mem_raddr = in_code_ext[CODE_W-1:3];
              state_nxt = S_RMRD;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_LROOT: begin
        if (!mem_rdata[1]) begin
          status_nxt = lols_pkg::ST_MISSING;
          state_nxt  = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cur_r[ROW_W-1:0];
          state_nxt = S_LWALK;
        end
      end
      S_LWALK: begin
        if (!mem_rdata[0]) begin
          state_nxt = S_OUT;
        end else if (!mem_rdata[oct]) begin
          status_nxt = lols_pkg::ST_MISSING;
          state_nxt  = S_OUT;
        end else begin
          half_nxt = half_child;
          cx_nxt   = oct[0] ? cx_r + ch_e : cx_r - ch_e;
          cy_nxt   = oct[1] ? cy_r + ch_e : cy_r - ch_e;
          cz_nxt   = oct[2] ? cz_r + ch_e : cz_r - ch_e;
          cur_nxt  = child;
          lvl_nxt  = lvl_r + 1'b1;
          if (lvl_r == LVL_W'(MAX_DEPTH - 1)) begin
            state_nxt = S_OUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = child[ROW_W-1:0];
          end
        end
      end
      S_SPCHK: begin
        if (!spl_valid || !mem_rdata[code_r[2:0]]) begin
          status_nxt = lols_pkg::ST_MISSING;
          state_nxt  = S_OUT;
        end else if (spl_lvl >= LVL_W'(MAX_DEPTH) || 3'(spl_lvl) >= root_depth_r) begin
          status_nxt = lols_pkg::ST_DEPTH0;
          state_nxt  = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = code_ext[ROW_W-1:0];
          state_nxt = S_SPCH0;
        end
      end
      S_SPCH0: begin
        if (mem_rdata[0]) begin
          status_nxt = lols_pkg::ST_SPLIT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = code_ext[ROW_W-1:0];
          mem_wdata = '1;
        end
        state_nxt = S_OUT;
      end
      S_RMRD: begin
        if (spl_valid) begin
          mem_we    = 1'b1;
          mem_waddr = code_ext[CODE_W-1:3];
          mem_wdata = mem_rdata & ~(lols_pkg::ROW_BITS'(1) << code_r[2:0]);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'd0,
                            geo ? depth_val : 3'd0,
                            geo ? half_r : 16'd0,
                            geo ? cz_r[15:0] : 16'd0,
                            geo ? cy_r[15:0] : 16'd0,
                            geo ? cx_r[15:0] : 16'd0,
                            leaf_val,
                            status_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
      root_size_r  <= lols_pkg::RESET_ROOT_SIZE;
      root_depth_r <= lols_pkg::RESET_ROOT_DEPTH;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        if (cfg_index[0] == lols_pkg::REG_ROOT_SIZE) begin
          root_size_r <= cfg_wdata;
        end else begin
          root_depth_r <= cfg_wdata[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    status_r    <= status_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    pz_r        <= pz_nxt;
    code_r      <= code_nxt;
    cur_r       <= cur_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cz_r        <= cz_nxt;
    half_r      <= half_nxt;
    lvl_r       <= lvl_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("Store read and write in the same cycle.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("A second transfer was taken while an item was at work.");

  a_walk_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LWALK) |-> (lvl_r < LVL_W'(MAX_DEPTH)))
    else $error("Locate walked past the deepest level.");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!in_tready && !out_tvalid_r))
    else $error("Traffic during the clearing pass.");
`endif

endmodule
